// File: rtl/core/btc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_pkg
// Shared widths, constants and types for the barometric compensation block.
// ----------------------------------------------------------------------------
package btc_pkg;

   localparam int RAW_W      = 20;
   localparam int OUT_W      = 32;
   localparam int FINE_W     = 24;
   localparam int COEF_W     = 16;
   localparam int WIDE_W     = 64;
   localparam int DIVISOR_W  = 31;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam int PRE_STAGES  = 12;
   localparam int DIV_STAGES  = 64;
   localparam int POST_STAGES = 7;
   localparam int NUM_STAGES  = PRE_STAGES + DIV_STAGES + POST_STAGES;

   localparam int FINE_OFFSET = 128000;
   localparam int DIV_SCALE   = 3125;

   localparam logic [RAW_W-1:0] RAW_MIN_RST = 20'd256;
   localparam logic [RAW_W-1:0] RAW_MAX_RST = 20'd1048560;

   typedef enum logic [2:0] {
      REG_CAL_TEMP   = 3'd0,
      REG_CAL_PLOW   = 3'd1,
      REG_CAL_PHIGH  = 3'd2,
      REG_CAL_P9     = 3'd3,
      REG_TEMP_MIN   = 3'd4,
      REG_TEMP_MAX   = 3'd5,
      REG_PRESS_MIN  = 3'd6,
      REG_PRESS_MAX  = 3'd7
   } csr_index_type;

   // per-sample data that rides along the pipeline
   typedef struct packed {
      logic [1:0]        rng;
      logic [RAW_W:0]    pr;
      logic [FINE_W-1:0] fine;
      logic [OUT_W-1:0]  temp;
      logic              invalid;
   } side_type;

endpackage
`default_nettype wire

// File: rtl/core/baro_temp_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_compensation
// Turns raw 20-bit temperature and pressure conversions into compensated
// temperature (0.01 degC), pressure (Q24.8 Pa) and the fine temperature term.
//
// Request channel req_*: one raw pair per request, taken when req_valid is
// high and req_stall low. Result channel rsp_*: one result per request, in
// order, held while rsp_stall is high. Calibration and bounds are written
// through the csr_* port; the user must write them only while no request
// is in flight; the block itself does not enforce this. Throughput is one
// request per clock while req_stall is low. A request passes through 12
// multiply/add stages, a 64-stage radix-2 divider (one quotient bit per
// stage) and 7 stages of final correction, then the output register.
// A stalled result sits in the output register while the pipeline keeps
// filling; the pipeline holds (and req_stall rises) only when its last
// stage has a result that the output register cannot take.
// Synchronous reset empties the pipeline and output register and loads the
// calibration registers with zero and the bounds with their defaults.
// ----------------------------------------------------------------------------
module baro_temp_compensation (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [btc_pkg::RAW_W-1:0]          req_raw_temperature,
   input  wire  [btc_pkg::RAW_W-1:0]          req_raw_pressure,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [btc_pkg::OUT_W-1:0]   rsp_temperature_centi,
   output logic [btc_pkg::OUT_W-1:0]          rsp_pressure_q24_8,
   output logic signed [btc_pkg::OUT_W-1:0]   rsp_fine_temperature,
   output logic                               rsp_pressure_invalid,
   output logic [1:0]                         rsp_raw_out_of_range,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [btc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [btc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [btc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import btc_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   // configuration
   logic [47:0]        cal_temp_ff, cal_temp_in;
   logic [63:0]        cal_plow_ff, cal_plow_in;
   logic [63:0]        cal_phigh_ff, cal_phigh_in;
   logic [15:0]        cal_p9_ff, cal_p9_in;
   logic [RAW_W-1:0]   tmin_ff, tmin_in, tmax_ff, tmax_in;
   logic [RAW_W-1:0]   pmin_ff, pmin_in, pmax_ff, pmax_in;
   csr_index_type      csr_index;
   logic               csr_wr;

   logic [COEF_W-1:0]        t1, p1;
   logic signed [COEF_W-1:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   // pipeline control
   logic                  adv;
   logic [LAST:0]         vld_ff, vld_in;
   side_type              side_ff [NUM_STAGES];
   side_type              side_in [NUM_STAGES];

   // stages s1..s12
   logic signed [17:0]    d1_s1_ff, d1_s1_in;
   logic signed [16:0]    d2_s1_ff, d2_s1_in;
   logic signed [33:0]    m1_s2_ff, m1_s2_in;
   logic [32:0]           sq_s2_ff, sq_s2_in;
   logic signed [33:0]    sq_full;
   logic signed [22:0]    v1t_s3_ff, v1t_s3_in;
   logic signed [37:0]    m2_s3_ff, m2_s3_in;
   logic signed [FINE_W-1:0] fine_s4;
   logic signed [24:0]    vp_s4_ff, vp_s4_in;
   logic signed [26:0]    temp_sc;
   logic signed [49:0]    a_full;
   logic [47:0]           a_s5_ff, a_s5_in;
   logic signed [40:0]    b5_s5_ff, b5_s5_in, b2_s5_ff, b2_s5_in;
   logic signed [40:0]    c6lo_s6_ff, c6lo_s6_in, c6hi_s6_ff, c6hi_s6_in;
   logic signed [40:0]    c3lo_s6_ff, c3lo_s6_in, c3hi_s6_ff, c3hi_s6_in;
   logic signed [40:0]    b5_s6_ff, b2_s6_ff;
   logic signed [63:0]    a6_s7_ff, a6_s7_in, a3_s7_ff, a3_s7_in;
   logic signed [40:0]    b5_s7_ff, b2_s7_ff;
   logic [63:0]           v2_s8_ff, v2_s8_in, x_s8_ff, x_s8_in;
   logic [63:0]           n0_s9_ff, n0_s9_in;
   logic [47:0]           xl_s9_ff, xl_s9_in;
   logic [31:0]           xh_s9_ff, xh_s9_in;
   logic [63:0]           y_s10;
   logic signed [DIVISOR_W-1:0] dv_s10_ff, dv_s10_in, dv_s11_ff;
   logic [43:0]           nlo_s10_ff, nlo_s10_in;
   logic [31:0]           nhi_s10_ff, nhi_s10_in;
   logic [63:0]           n_s11_ff, n_s11_in;
   logic [63:0]           mn_s12_ff, mn_s12_in;
   logic [DIVISOR_W-1:0]  md_s12_ff, md_s12_in;
   logic                  neg_s12_ff, neg_s12_in;

   // divider
   logic [DIVISOR_W-1:0]  div_rem_ff [DIV_STAGES];
   logic [DIVISOR_W-1:0]  div_rem_in [DIV_STAGES];
   logic [63:0]           div_dq_ff [DIV_STAGES];
   logic [63:0]           div_dq_in [DIV_STAGES];
   logic [DIVISOR_W-1:0]  div_md_ff [DIV_STAGES];
   logic [DIVISOR_W-1:0]  div_md_in [DIV_STAGES];
   logic                  div_neg_ff [DIV_STAGES];
   logic                  div_neg_in [DIV_STAGES];
   logic [DIVISOR_W-1:0]  div_src_rem [DIV_STAGES];
   logic [63:0]           div_src_dq [DIV_STAGES];
   logic [DIVISOR_W-1:0]  div_src_md [DIV_STAGES];
   logic                  div_src_neg [DIV_STAGES];
   logic [DIVISOR_W:0]    div_trial [DIV_STAGES];

   // stages e1..e7
   logic signed [63:0]    p_e1_ff, p_e1_in, p_e2_ff, p_e3_ff, p_e4_ff, p_e5_ff;
   logic signed [63:0]    ps_e1;
   logic [63:0]           mll_e2_ff, mll_e2_in;
   logic [31:0]           mhl_e2_ff, mhl_e2_in;
   logic signed [48:0]    pl8_e2_ff, pl8_e2_in;
   logic [31:0]           ph8_e2_ff, ph8_e2_in;
   logic [63:0]           sq_e3_ff, sq_e3_in;
   logic signed [63:0]    w8_e3_ff, w8_e3_in, w8_e4_ff, w8_e5_ff;
   logic signed [48:0]    ql9_e4_ff, ql9_e4_in;
   logic [31:0]           qh9_e4_ff, qh9_e4_in;
   logic signed [63:0]    m_e5_ff, m_e5_in;
   logic signed [63:0]    sum_e6;
   logic [31:0]           sumh_e6_ff, sumh_e6_in;
   logic [31:0]           press_e7_ff, press_e7_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      out_temp_ff, out_press_ff;
   logic [FINE_W-1:0]     out_fine_ff;
   logic                  out_invalid_ff;
   logic [1:0]            out_rng_ff;

   // ------------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------------
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cal_temp_in  = cal_temp_ff;
      cal_plow_in  = cal_plow_ff;
      cal_phigh_in = cal_phigh_ff;
      cal_p9_in    = cal_p9_ff;
      tmin_in      = tmin_ff;
      tmax_in      = tmax_ff;
      pmin_in      = pmin_ff;
      pmax_in      = pmax_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_CAL_TEMP:  cal_temp_in  = csr_pwdata[47:0];
            REG_CAL_PLOW:  cal_plow_in  = csr_pwdata;
            REG_CAL_PHIGH: cal_phigh_in = csr_pwdata;
            REG_CAL_P9:    cal_p9_in    = csr_pwdata[15:0];
            REG_TEMP_MIN:  tmin_in      = csr_pwdata[RAW_W-1:0];
            REG_TEMP_MAX:  tmax_in      = csr_pwdata[RAW_W-1:0];
            REG_PRESS_MIN: pmin_in      = csr_pwdata[RAW_W-1:0];
            REG_PRESS_MAX: pmax_in      = csr_pwdata[RAW_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CAL_TEMP:  csr_prdata = {16'b0, cal_temp_ff};
         REG_CAL_PLOW:  csr_prdata = cal_plow_ff;
         REG_CAL_PHIGH: csr_prdata = cal_phigh_ff;
         REG_CAL_P9:    csr_prdata = {48'b0, cal_p9_ff};
         REG_TEMP_MIN:  csr_prdata = {44'b0, tmin_ff};
         REG_TEMP_MAX:  csr_prdata = {44'b0, tmax_ff};
         REG_PRESS_MIN: csr_prdata = {44'b0, pmin_ff};
         REG_PRESS_MAX: csr_prdata = {44'b0, pmax_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff  <= '0;
         cal_plow_ff  <= '0;
         cal_phigh_ff <= '0;
         cal_p9_ff    <= '0;
         tmin_ff      <= RAW_MIN_RST;
         tmax_ff      <= RAW_MAX_RST;
         pmin_ff      <= RAW_MIN_RST;
         pmax_ff      <= RAW_MAX_RST;
      end else begin
         cal_temp_ff  <= cal_temp_in;
         cal_plow_ff  <= cal_plow_in;
         cal_phigh_ff <= cal_phigh_in;
         cal_p9_ff    <= cal_p9_in;
         tmin_ff      <= tmin_in;
         tmax_ff      <= tmax_in;
         pmin_ff      <= pmin_in;
         pmax_ff      <= pmax_in;
      end
   end

   assign t1 = cal_temp_ff[15:0];
   assign t2 = $signed(cal_temp_ff[31:16]);
   assign t3 = $signed(cal_temp_ff[47:32]);
   assign p1 = cal_plow_ff[15:0];
   assign p2 = $signed(cal_plow_ff[31:16]);
   assign p3 = $signed(cal_plow_ff[47:32]);
   assign p4 = $signed(cal_plow_ff[63:48]);
   assign p5 = $signed(cal_phigh_ff[15:0]);
   assign p6 = $signed(cal_phigh_ff[31:16]);
   assign p7 = $signed(cal_phigh_ff[47:32]);
   assign p8 = $signed(cal_phigh_ff[63:48]);
   assign p9 = $signed(cal_p9_ff);

   // ------------------------------------------------------------------------
   // flow control: whole pipeline moves together
   // ------------------------------------------------------------------------
   assign adv       = !(vld_ff[LAST] && rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      vld_in = {vld_ff[LAST-1:0], req_valid};
      if (adv && vld_ff[LAST]) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // ------------------------------------------------------------------------
   // temperature path and pressure coefficient terms
   // ------------------------------------------------------------------------
   always_comb begin
      // s1: offsets and range flags
      d1_s1_in = $signed({1'b0, req_raw_temperature[RAW_W-1:3]}) -
                 $signed({1'b0, t1, 1'b0});
      d2_s1_in = $signed({1'b0, req_raw_temperature[RAW_W-1:4]}) - $signed({1'b0, t1});

      // s2
      m1_s2_in = 34'(d1_s1_ff) * 34'(t2);
      sq_full  = 34'(d2_s1_ff) * 34'(d2_s1_ff);
      sq_s2_in = sq_full[32:0];

      // s3
      v1t_s3_in = m1_s2_ff[33:11];
      m2_s3_in  = 38'($signed({1'b0, sq_s2_ff[32:12]})) * 38'(t3);

      // s4: fine temperature
      fine_s4  = 24'(v1t_s3_ff) + m2_s3_ff[37:14];
      vp_s4_in = 25'(fine_s4) - 25'(FINE_OFFSET);

      // s5
      a_full   = 50'(vp_s4_ff) * 50'(vp_s4_ff);
      a_s5_in  = a_full[47:0];
      b5_s5_in = 41'(vp_s4_ff) * 41'(p5);
      b2_s5_in = 41'(vp_s4_ff) * 41'(p2);
      temp_sc  = (27'($signed(side_ff[3].fine)) <<< 2) +
                 27'($signed(side_ff[3].fine)) + 27'sd128;

      // s6: square times p6 and p3, in halves
      c6lo_s6_in = 41'($signed({1'b0, a_s5_ff[23:0]})) * 41'(p6);
      c6hi_s6_in = 41'($signed({1'b0, a_s5_ff[47:24]})) * 41'(p6);
      c3lo_s6_in = 41'($signed({1'b0, a_s5_ff[23:0]})) * 41'(p3);
      c3hi_s6_in = 41'($signed({1'b0, a_s5_ff[47:24]})) * 41'(p3);

      // s7
      a6_s7_in = (64'(c6hi_s6_ff) <<< 24) + 64'(c6lo_s6_ff);
      a3_s7_in = (64'(c3hi_s6_ff) <<< 24) + 64'(c3lo_s6_ff);

      // s8
      v2_s8_in = a6_s7_ff + (64'(b5_s7_ff) <<< 17) + (64'(p4) <<< 35);
      x_s8_in  = (a3_s7_ff >>> 8) + (64'(b2_s7_ff) <<< 12) + (64'sd1 <<< 47);

      // s9: divisor partial products, dividend base
      xl_s9_in = 48'(x_s8_ff[31:0]) * 48'(p1);
      xh_s9_in = x_s8_ff[63:32] * 32'(p1);
      n0_s9_in = {12'b0, side_ff[7].pr, 31'b0} - v2_s8_ff;

      // s10
      y_s10      = 64'(xl_s9_ff) + {xh_s9_ff, 32'b0};
      dv_s10_in  = $signed(y_s10[63:33]);
      nlo_s10_in = 44'(n0_s9_ff[31:0]) * 44'(DIV_SCALE);
      nhi_s10_in = n0_s9_ff[63:32] * 32'(DIV_SCALE);

      // s11
      n_s11_in = 64'(nlo_s10_ff) + {nhi_s10_ff, 32'b0};

      // s12: magnitudes for the unsigned divider
      mn_s12_in  = n_s11_ff[63] ? (64'd0 - n_s11_ff) : n_s11_ff;
      md_s12_in  = dv_s11_ff[DIVISOR_W-1] ? (DIVISOR_W'(0) - DIVISOR_W'(dv_s11_ff)) :
                                            DIVISOR_W'(dv_s11_ff);
      neg_s12_in = n_s11_ff[63] ^ dv_s11_ff[DIVISOR_W-1];
   end

   // side data
   always_comb begin
      side_in[0].rng[0] = (req_raw_temperature <= tmin_ff) ||
                          (req_raw_temperature >= tmax_ff);
      side_in[0].rng[1] = (req_raw_pressure <= pmin_ff) || (req_raw_pressure >= pmax_ff);
      side_in[0].pr      = 21'(1 << RAW_W) - {1'b0, req_raw_pressure};
      side_in[0].fine    = '0;
      side_in[0].temp    = '0;
      side_in[0].invalid = 1'b0;
      for (int k = 1; k < NUM_STAGES; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[3].fine     = fine_s4;
      side_in[4].temp     = 32'(temp_sc >>> 8);
      side_in[10].invalid = (dv_s10_ff == '0);
   end

   // ------------------------------------------------------------------------
   // restoring divider, one quotient bit per stage; dividend shifts out as
   // quotient shifts in
   // ------------------------------------------------------------------------
   always_comb begin
      div_src_rem[0] = '0;
      div_src_dq[0]  = mn_s12_ff;
      div_src_md[0]  = md_s12_ff;
      div_src_neg[0] = neg_s12_ff;
      for (int j = 1; j < DIV_STAGES; j++) begin
         div_src_rem[j] = div_rem_ff[j-1];
         div_src_dq[j]  = div_dq_ff[j-1];
         div_src_md[j]  = div_md_ff[j-1];
         div_src_neg[j] = div_neg_ff[j-1];
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
         div_trial[j]  = {div_src_rem[j], div_src_dq[j][63]};
         div_md_in[j]  = div_src_md[j];
         div_neg_in[j] = div_src_neg[j];
         if (div_trial[j] >= {1'b0, div_src_md[j]}) begin
            div_rem_in[j] = DIVISOR_W'(div_trial[j] - {1'b0, div_src_md[j]});
            div_dq_in[j]  = {div_src_dq[j][62:0], 1'b1};
         end else begin
            div_rem_in[j] = div_trial[j][DIVISOR_W-1:0];
            div_dq_in[j]  = {div_src_dq[j][62:0], 1'b0};
         end
      end
   end

   // ------------------------------------------------------------------------
   // pressure correction, all modulo 2^64
   // ------------------------------------------------------------------------
   always_comb begin
      // e1
      p_e1_in = div_neg_ff[DIV_STAGES-1] ? $signed(64'd0 - div_dq_ff[DIV_STAGES-1]) :
                                           $signed(div_dq_ff[DIV_STAGES-1]);

      // e2: (p >>> 13)^2 and p * p8 as 32-bit partial products
      ps_e1     = p_e1_ff >>> 13;
      mll_e2_in = 64'(ps_e1[31:0]) * 64'(ps_e1[31:0]);
      mhl_e2_in = ps_e1[63:32] * ps_e1[31:0];
      pl8_e2_in = 49'($signed({1'b0, p_e1_ff[31:0]})) * 49'(p8);
      ph8_e2_in = p_e1_ff[63:32] * 32'(p8);

      // e3: cross term appears twice, hence the extra shift
      sq_e3_in = mll_e2_ff + {mhl_e2_ff[30:0], 33'b0};
      w8_e3_in = 64'(pl8_e2_ff) + $signed({ph8_e2_ff, 32'b0});

      // e4
      ql9_e4_in = 49'($signed({1'b0, sq_e3_ff[31:0]})) * 49'(p9);
      qh9_e4_in = sq_e3_ff[63:32] * 32'(p9);

      // e5
      m_e5_in = 64'(ql9_e4_ff) + $signed({qh9_e4_ff, 32'b0});

      // e6: only bits 39:8 of the sum reach the output
      sum_e6     = p_e5_ff + (m_e5_ff >>> 25) + (w8_e5_ff >>> 19);
      sumh_e6_in = sum_e6[39:8];

      // e7
      if (side_ff[LAST-1].invalid) begin
         press_e7_in = '0;
      end else begin
         press_e7_in = sumh_e6_ff + (32'(p7) << 4);
      end
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff    <= side_in;
         d1_s1_ff   <= d1_s1_in;
         d2_s1_ff   <= d2_s1_in;
         m1_s2_ff   <= m1_s2_in;
         sq_s2_ff   <= sq_s2_in;
         v1t_s3_ff  <= v1t_s3_in;
         m2_s3_ff   <= m2_s3_in;
         vp_s4_ff   <= vp_s4_in;
         a_s5_ff    <= a_s5_in;
         b5_s5_ff   <= b5_s5_in;
         b2_s5_ff   <= b2_s5_in;
         c6lo_s6_ff <= c6lo_s6_in;
         c6hi_s6_ff <= c6hi_s6_in;
         c3lo_s6_ff <= c3lo_s6_in;
         c3hi_s6_ff <= c3hi_s6_in;
         b5_s6_ff   <= b5_s5_ff;
         b2_s6_ff   <= b2_s5_ff;
         a6_s7_ff   <= a6_s7_in;
         a3_s7_ff   <= a3_s7_in;
         b5_s7_ff   <= b5_s6_ff;
         b2_s7_ff   <= b2_s6_ff;
         v2_s8_ff   <= v2_s8_in;
         x_s8_ff    <= x_s8_in;
         n0_s9_ff   <= n0_s9_in;
         xl_s9_ff   <= xl_s9_in;
         xh_s9_ff   <= xh_s9_in;
         dv_s10_ff  <= dv_s10_in;
         nlo_s10_ff <= nlo_s10_in;
         nhi_s10_ff <= nhi_s10_in;
         n_s11_ff   <= n_s11_in;
         dv_s11_ff  <= dv_s10_ff;
         mn_s12_ff  <= mn_s12_in;
         md_s12_ff  <= md_s12_in;
         neg_s12_ff <= neg_s12_in;
         div_rem_ff <= div_rem_in;
         div_dq_ff  <= div_dq_in;
         div_md_ff  <= div_md_in;
         div_neg_ff <= div_neg_in;
         p_e1_ff    <= p_e1_in;
         p_e2_ff    <= p_e1_ff;
         mll_e2_ff  <= mll_e2_in;
         mhl_e2_ff  <= mhl_e2_in;
         pl8_e2_ff  <= pl8_e2_in;
         ph8_e2_ff  <= ph8_e2_in;
         p_e3_ff    <= p_e2_ff;
         sq_e3_ff   <= sq_e3_in;
         w8_e3_ff   <= w8_e3_in;
         p_e4_ff    <= p_e3_ff;
         w8_e4_ff   <= w8_e3_ff;
         ql9_e4_ff  <= ql9_e4_in;
         qh9_e4_ff  <= qh9_e4_in;
         p_e5_ff    <= p_e4_ff;
         w8_e5_ff   <= w8_e4_ff;
         m_e5_ff    <= m_e5_in;
         sumh_e6_ff <= sumh_e6_in;
         press_e7_ff <= press_e7_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[LAST]) begin
         out_temp_ff    <= side_ff[LAST].temp;
         out_fine_ff    <= side_ff[LAST].fine;
         out_rng_ff     <= side_ff[LAST].rng;
         out_invalid_ff <= side_ff[LAST].invalid;
         out_press_ff   <= press_e7_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = $signed(out_temp_ff);
   assign rsp_pressure_q24_8    = out_press_ff;
   assign rsp_fine_temperature  = 32'($signed(out_fine_ff));
   assign rsp_pressure_invalid  = out_invalid_ff;
   assign rsp_raw_out_of_range  = out_rng_ff;

endmodule
`default_nettype wire

// File: rtl/core/btc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_checker
// Port-level checks on the result channel of the compensation block.
// ----------------------------------------------------------------------------
module btc_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire signed [btc_pkg::OUT_W-1:0]    rsp_temperature_centi,
   input wire [btc_pkg::OUT_W-1:0]           rsp_pressure_q24_8,
   input wire signed [btc_pkg::OUT_W-1:0]    rsp_fine_temperature,
   input wire                                rsp_pressure_invalid
);
   logic signed [39:0] chk_temp;

   // temperature is the fine term times 5/256, rounded
   assign chk_temp = (40'(rsp_fine_temperature) * 40'sd5 + 40'sd128) >>> 8;

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && rsp_stall |=> $stable(rsp_temperature_centi) &&
      $stable(rsp_pressure_q24_8) && $stable(rsp_fine_temperature))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_invalid |-> rsp_pressure_q24_8 == '0)
      else $error("invalid pressure not forced to zero");

   a_temp_fine: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 40'(rsp_temperature_centi) == chk_temp)
      else $error("temperature does not follow fine term");

endmodule

bind baro_temp_compensation btc_checker u_btc_checker (.*);
`default_nettype wire

// File: verif/tb_baro_temp_compensation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_temp_compensation
// Self-checking bench for the barometric compensation block. Random raw
// pairs go through the request channel and calibration sets through csr_*,
// with bursty idling on both sides; an integer-form predictor computes the
// expected temperature, pressure, fine term and flags for each request.
// ----------------------------------------------------------------------------
module tb_baro_temp_compensation;
   import btc_pkg::*;

   typedef struct {
      logic [31:0] temp;
      logic [31:0] press;
      logic [31:0] fine;
      logic        invalid;
      logic [1:0]  rng;
   } comp_result_type;

   class comp_scoreboard;
      logic [63:0] cal_temp, cal_plow, cal_phigh, cal_p9;
      logic [19:0] tmin, tmax, pmin, pmax;
      comp_result_type pending[$];
      int mismatches;

      function void set_reg(csr_index_type idx, logic [63:0] v);
         case (idx)
            REG_CAL_TEMP:  cal_temp = {16'd0, v[47:0]};
            REG_CAL_PLOW:  cal_plow = v;
            REG_CAL_PHIGH: cal_phigh = v;
            REG_CAL_P9:    cal_p9 = {48'd0, v[15:0]};
            REG_TEMP_MIN:  tmin = v[19:0];
            REG_TEMP_MAX:  tmax = v[19:0];
            REG_PRESS_MIN: pmin = v[19:0];
            REG_PRESS_MAX: pmax = v[19:0];
            default: ;
         endcase
      endfunction

      function void clear();
         cal_temp = 0; cal_plow = 0; cal_phigh = 0; cal_p9 = 0;
         tmin = RAW_MIN_RST; tmax = RAW_MAX_RST;
         pmin = RAW_MIN_RST; pmax = RAW_MAX_RST;
      endfunction

      function logic signed [63:0] sx(logic [15:0] v);
         return {{48{v[15]}}, v};
      endfunction

      // truncating signed divide with 64-bit wrap
      function logic signed [63:0] div_trunc(logic signed [63:0] n, logic signed [63:0] d);
         logic [63:0] mn, md, q;
         mn = n[63] ? -n : n;
         md = d[63] ? -d : d;
         q = mn / md;
         return (n[63] != d[63]) ? -q : q;
      endfunction

      function void note_request(logic [19:0] rt, logic [19:0] rp);
         logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic signed [63:0] d1, d2, a, b, fine, p;
         comp_result_type r;
         t1 = {48'd0, cal_temp[15:0]}; t2 = sx(cal_temp[31:16]); t3 = sx(cal_temp[47:32]);
         p1 = {48'd0, cal_plow[15:0]}; p2 = sx(cal_plow[31:16]);
         p3 = sx(cal_plow[47:32]); p4 = sx(cal_plow[63:48]);
         p5 = sx(cal_phigh[15:0]); p6 = sx(cal_phigh[31:16]);
         p7 = sx(cal_phigh[47:32]); p8 = sx(cal_phigh[63:48]); p9 = sx(cal_p9[15:0]);
         d1 = (rt >> 3) - (t1 <<< 1);
         a = (d1 * t2) >>> 11;
         d2 = (rt >> 4) - t1;
         b = (((d2 * d2) >>> 12) * t3) >>> 14;
         fine = a + b;
         r.fine = fine[31:0];
         a = (fine * 5 + 128) >>> 8;
         r.temp = a[31:0];
         a = fine - 128000;
         b = a * a * p6;
         b = b + ((a * p5) <<< 17);
         b = b + (p4 <<< 35);
         a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
         a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
         if (a == 0) begin
            r.invalid = 1'b1;
            r.press = 0;
         end else begin
            r.invalid = 1'b0;
            p = 64'sd1048576 - rp;
            p = div_trunc(((p <<< 31) - b) * 3125, a);
            a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            b = (p8 * p) >>> 19;
            p = ((p + a + b) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
         end
         r.rng[0] = (rt <= tmin) || (rt >= tmax);
         r.rng[1] = (rp <= pmin) || (rp >= pmax);
         pending.push_back(r);
      endfunction

      function void check_result(comp_result_type got);
         comp_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $time);
            return;
         end
         e = pending.pop_front();
         if (got.temp !== e.temp || got.press !== e.press || got.fine !== e.fine ||
             got.invalid !== e.invalid || got.rng !== e.rng) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp t=%h p=%h f=%h i=%b r=%b got t=%h p=%h f=%h i=%b r=%b",
                        e.temp, e.press, e.fine, e.invalid, e.rng,
                        got.temp, got.press, got.fine, got.invalid, got.rng);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   logic [19:0] req_raw_temperature = 0, req_raw_pressure = 0;
   wire req_stall, rsp_valid, rsp_pressure_invalid, csr_pready;
   wire [31:0] rsp_temperature_centi, rsp_pressure_q24_8, rsp_fine_temperature;
   wire [1:0] rsp_raw_out_of_range;
   wire [63:0] csr_prdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = 0;
   logic [63:0] csr_pwdata = 0;
   logic quiet = 0;

   comp_scoreboard sb = new();

   always #1 clock = ~clock;

   baro_temp_compensation dut (.*);

   task automatic csr_write(csr_index_type idx, logic [63:0] v);
      @(negedge clock);
      csr_psel = 1; csr_pwrite = 1; csr_paddr = CSR_ADDR_W'(8 * idx); csr_pwdata = v;
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
      sb.set_reg(idx, v);
   endtask

   task automatic send_raw(logic [19:0] rt, logic [19:0] rp);
      if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 14)) @(negedge clock);
      req_valid = 1; req_raw_temperature = rt; req_raw_pressure = rp;
      do @(posedge clock); while (req_stall);
      sb.note_request(rt, rp);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 10) @(posedge clock);
   endtask

   // coefficients by mode: factory-like with noise, extremes, zero p1, else random
   task automatic load_cal(int mode);
      logic [63:0] t, pl, ph, p9;
      t = {$urandom, $urandom}; pl = {$urandom, $urandom};
      ph = {$urandom, $urandom}; p9 = 64'($urandom);
      if (mode == 0) begin
         t = 64'({16'h0032, 16'h6800, 16'h6E00 + 16'($urandom_range(0, 511))});
         pl = {16'h2000 + 16'($urandom_range(0, 255)), 16'hF000, 16'hD5D0, 16'h8E00};
         ph = {16'h2000, 16'h2200, 16'hFFF9, 16'h008C};
         p9 = 64'h1770;
      end else if (mode == 1) begin
         t = 64'h0000_FFFF_7FFF_8000; pl = 64'h7FFF_8000_7FFF_FFFF;
         ph = 64'h8000_7FFF_8000_7FFF; p9 = 64'h8000;
      end else if (mode == 2) begin
         pl[15:0] = 0;  // zero divisor
      end
      csr_write(REG_CAL_TEMP, t);
      csr_write(REG_CAL_PLOW, pl);
      csr_write(REG_CAL_PHIGH, ph);
      csr_write(REG_CAL_P9, p9);
   endtask

   // response side
   always @(negedge clock) begin
      if (reset || quiet) rsp_stall <= 0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 3) != 0);
      else rsp_stall <= ($urandom_range(0, 9) == 0);
   end

   always @(posedge clock) begin
      comp_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.temp = rsp_temperature_centi; got.press = rsp_pressure_q24_8;
         got.fine = rsp_fine_temperature; got.invalid = rsp_pressure_invalid;
         got.rng = rsp_raw_out_of_range;
         sb.check_result(got);
      end
   end

   initial begin
      #200000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      sb.clear();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: defaults (zero cal gives zero divisor), extremes, bounds edges
      send_raw(0, 0);
      send_raw(20'hFFFFF, 20'hFFFFF);
      send_raw(256, 256);
      send_raw(257, 257);
      send_raw(1048560, 1048560);
      send_raw(1048559, 1048559);
      drain();
      load_cal(0);
      send_raw(20'h7EED0, 20'h65A00);
      send_raw(0, 20'hFFFFF);
      send_raw(20'hFFFFF, 0);
      send_raw(20'hAAAAA, 20'h55555);
      send_raw(20'h55555, 20'hAAAAA);
      drain();
      load_cal(1);
      send_raw(0, 0);
      send_raw(20'hFFFFF, 20'hFFFFF);
      send_raw(20'h80000, 20'h80000);
      drain();
      csr_write(REG_TEMP_MIN, 0);
      csr_write(REG_TEMP_MAX, 64'h0_FFFFF);
      csr_write(REG_PRESS_MIN, 64'h0_FFFFF);
      csr_write(REG_PRESS_MAX, 0);
      send_raw(0, 0);
      send_raw(20'hFFFFF, 20'h12345);
      send_raw(20'h00001, 20'hFFFFE);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         load_cal(ph < 4 ? 0 : (ph == 5 ? 2 : 3));
         csr_write(REG_TEMP_MIN, 64'($urandom_range(0, 1000)));
         csr_write(REG_TEMP_MAX, 64'($urandom_range(20'hFFC00, 20'hFFFFF)));
         csr_write(REG_PRESS_MIN, 64'($urandom_range(0, 20'h40000)));
         csr_write(REG_PRESS_MAX, 64'($urandom_range(20'hC0000, 20'hFFFFF)));
         if (ph == 7) quiet = 1;
         for (int i = 0; i < 100; i++) begin
            if ($urandom_range(0, 3) != 0)
               send_raw(20'($urandom_range(20'h60000, 20'h90000)),
                        20'($urandom_range(20'h40000, 20'hA0000)));
            else
               send_raw(20'($urandom), 20'($urandom));
         end
         drain();
      end
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
